FILE: hw/rtl/cabm_pkg.sv
package cabm_pkg;

	// Command codes
	localparam logic [2:0] CMD_CREATE  = 3'd0;
	localparam logic [2:0] CMD_RESERVE = 3'd1;
	localparam logic [2:0] CMD_PUT     = 3'd2;
	localparam logic [2:0] CMD_GET     = 3'd3;
	localparam logic [2:0] CMD_UNGET   = 3'd4;
	localparam logic [2:0] CMD_DELETE  = 3'd5;

	// Status codes
	localparam logic [2:0] STS_OK        = 3'd0;
	localparam logic [2:0] STS_BAD_ID    = 3'd1;
	localparam logic [2:0] STS_CLOSED    = 3'd2;
	localparam logic [2:0] STS_NO_BUF    = 3'd3;
	localparam logic [2:0] STS_BAD_COUNT = 3'd4;
	localparam logic [2:0] STS_NO_SET    = 3'd5;

	typedef struct packed {
		logic [2:0] command;
		logic [2:0] cab_id;
		logic [3:0] buffer_index;
		logic [4:0] buffer_count;
	} cabm_req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [1:0] result_cab;
		logic [3:0] result_buffer;
	} cabm_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_SWEEP
	} cabm_state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic sweep;
	} cabm_ctl_t;

	// Datapath to controller
	typedef struct packed {
		logic out_busy;
		logic create_go;
		logic sweep_last;
	} cabm_sts_t;

endpackage

FILE: hw/rtl/cabm_ctrl.sv
module cabm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  cabm_pkg::cabm_sts_t sts,
	output cabm_pkg::cabm_ctl_t ctl
);
	import cabm_pkg::*;

	cabm_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequence one word: read, execute once the result register is free, optional sweep
	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		cmd_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					ctl.load = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				// hold while the previous result is still waiting
				if (!sts.out_busy) begin
					ctl.exec = 1'b1;
					state_d  = sts.create_go ? ST_SWEEP : ST_IDLE;
				end
			end
			ST_SWEEP: begin
				ctl.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/cabm_dp.sv
module cabm_dp #(
	parameter int CABS = 4,
	parameter int BUFS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cabm_pkg::cabm_ctl_t ctl,
	output cabm_pkg::cabm_sts_t sts,
	input  cabm_pkg::cabm_req_t cmd_word,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output cabm_pkg::cabm_rsp_t rsp_word
);
	import cabm_pkg::*;

	localparam int SIW = (CABS > 1) ? $clog2(CABS) : 1;
	localparam int SW  = $clog2(CABS + 1);
	localparam int BW  = $clog2(BUFS + 1);
	localparam int AW  = $clog2(CABS * BUFS);
	localparam int MD  = CABS * BUFS;

	function automatic logic [AW-1:0] mem_addr(input logic [SIW-1:0] s, input logic [BW-1:0] b);
		mem_addr = AW'(32'(s) * 32'(BUFS) + 32'(b));
	endfunction

	// Captured command word
	cabm_req_t req_q;

	// Per-set state
	logic          set_open_q  [CABS];
	logic [SW-1:0] next_free_q [CABS];
	logic [SW-1:0] set_head_q;
	logic [BW-1:0] latest_q    [CABS];
	logic [BW-1:0] fhead_q     [CABS];
	logic [BW-1:0] fcnt_q      [CABS];

	// Buffer memories
	logic [BW-1:0] link_mem [MD];
	logic [7:0]    uc_mem   [MD];
	logic [BW-1:0] rd_link_q;
	logic [7:0]    rd_uc_q;

	// Sweep control
	logic [SIW-1:0] sw_set_q;
	logic [BW-1:0]  sw_i_q;

	// Result register
	logic      out_valid_q;
	cabm_rsp_t out_q;

	logic [SIW-1:0] s, snew, tgt;
	logic           id_bad, bi_bad, cnt_bad;
	logic [2:0]     chk;
	logic [BW-1:0]  bi_b, lat, fh, fc;
	logic [AW-1:0]  uc_ra, lk_ra;
	logic [2:0]     st;
	logic [SIW-1:0] rcab;
	logic [BW-1:0]  rbuf;
	logic           uc_we, lk_we;
	logic [AW-1:0]  uc_wa, lk_wa;
	logic [7:0]     uc_wd;
	logic [BW-1:0]  lk_wd;
	logic           lat_we, fh_we, fc_we, do_create, do_delete;
	logic [BW-1:0]  n_lat, n_fh, n_fc;

	// Decode the held word against current state
	always_comb begin
		s      = SIW'(req_q.cab_id);
		snew   = SIW'(set_head_q);
		id_bad = 32'(req_q.cab_id) >= 32'(CABS);
		bi_bad = 32'(req_q.buffer_index) >= 32'(BUFS);
		cnt_bad = (req_q.buffer_count == 5'd0) || (32'(req_q.buffer_count) > 32'(BUFS));
		chk    = id_bad ? STS_BAD_ID : (!set_open_q[s] ? STS_CLOSED : STS_OK);
		bi_b   = BW'(req_q.buffer_index);
		lat    = latest_q[s];
		fh     = fhead_q[s];
		fc     = fcnt_q[s];
		uc_ra  = (req_q.command == CMD_UNGET) ? mem_addr(s, bi_b) : mem_addr(s, lat);
		lk_ra  = mem_addr(s, fh);
	end

	// Work out the update and the result
	always_comb begin
		st = STS_OK;
		rcab = '0;
		rbuf = '0;
		uc_we = 1'b0; uc_wa = uc_ra; uc_wd = '0;
		lk_we = 1'b0; lk_wa = mem_addr(s, lat); lk_wd = fh;
		lat_we = 1'b0; fh_we = 1'b0; fc_we = 1'b0;
		n_lat = bi_b; n_fh = fh; n_fc = fc;
		do_create = 1'b0; do_delete = 1'b0;
		tgt = s;
		unique case (req_q.command) inside
			CMD_CREATE: begin
				if (cnt_bad) begin
					st = STS_BAD_COUNT;
				end else if (32'(set_head_q) >= 32'(CABS)) begin
					st = STS_NO_SET;
				end else begin
					do_create = 1'b1;
					tgt = snew;
					rcab = snew;
					lat_we = 1'b1; n_lat = '0;
					fh_we = 1'b1;
					n_fh = (req_q.buffer_count > 5'd1) ? BW'(1) : BW'(BUFS);
					fc_we = 1'b1;
					n_fc = BW'(req_q.buffer_count - 5'd1);
				end
			end
			CMD_RESERVE, CMD_PUT, CMD_GET, CMD_UNGET, CMD_DELETE: begin
				st = chk;
				if (chk == STS_OK && bi_bad &&
				    (req_q.command == CMD_PUT || req_q.command == CMD_UNGET)) begin
					st = STS_BAD_COUNT;
				end else if (chk == STS_OK) begin
					unique case (req_q.command)
						CMD_RESERVE: begin
							if (fc == '0 || 32'(fh) >= 32'(BUFS)) begin
								st = STS_NO_BUF;
							end else begin
								rbuf = fh;
								fh_we = 1'b1; n_fh = rd_link_q;
								fc_we = 1'b1; n_fc = fc - BW'(1);
							end
						end
						CMD_PUT: begin
							lat_we = 1'b1;
							if (32'(lat) < 32'(BUFS) && rd_uc_q == 8'd0) begin
								lk_we = 1'b1;
								fh_we = 1'b1; n_fh = lat;
								fc_we = 1'b1;
								n_fc = (32'(fc) < 32'(BUFS)) ? fc + BW'(1) : fc;
							end
						end
						CMD_GET: begin
							if (32'(lat) < 32'(BUFS)) begin
								rbuf = lat;
								uc_we = 1'b1;
								uc_wd = (rd_uc_q != 8'hFF) ? rd_uc_q + 8'd1 : rd_uc_q;
							end
						end
						CMD_UNGET: begin
							if (rd_uc_q != 8'd0) begin
								uc_we = 1'b1;
								uc_wd = rd_uc_q - 8'd1;
								if (rd_uc_q == 8'd1 && bi_b != lat) begin
									lk_we = 1'b1;
									lk_wa = mem_addr(s, bi_b);
									fh_we = 1'b1; n_fh = bi_b;
									fc_we = 1'b1;
									n_fc = (32'(fc) < 32'(BUFS)) ? fc + BW'(1) : fc;
								end
							end
						end
						default: begin
							do_delete = 1'b1;
						end
					endcase
				end
			end
			default: begin
				st = STS_OK;
			end
		endcase
	end

	// Capture the accepted word
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			req_q <= cmd_word;
		end
	end

	// Set bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CABS; i++) begin
				set_open_q[i]  <= 1'b0;
				next_free_q[i] <= SW'(i + 1);
			end
			set_head_q <= '0;
		end else if (ctl.exec) begin
			if (do_create) begin
				set_open_q[snew] <= 1'b1;
				set_head_q       <= next_free_q[snew];
			end else if (do_delete) begin
				set_open_q[s]  <= 1'b0;
				next_free_q[s] <= set_head_q;
				set_head_q     <= SW'(s);
			end
		end
	end

	// Latest buffer and free list head and count
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			if (lat_we) latest_q[tgt] <= n_lat;
			if (fh_we)  fhead_q[tgt]  <= n_fh;
			if (fc_we)  fcnt_q[tgt]   <= n_fc;
		end
	end

	// Sweep index: clear use counts and chain the free list after create
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_i_q   <= '0;
			sw_set_q <= '0;
		end else if (ctl.exec) begin
			sw_i_q   <= '0;
			sw_set_q <= snew;
		end else if (ctl.sweep) begin
			sw_i_q <= sw_i_q + BW'(1);
		end
	end

	// Memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (ctl.sweep) begin
			uc_mem[mem_addr(sw_set_q, sw_i_q)] <= 8'd0;
		end else if (ctl.exec && uc_we) begin
			uc_mem[uc_wa] <= uc_wd;
		end
		rd_uc_q <= uc_mem[uc_ra];
	end

	always_ff @(posedge clk) begin
		if (ctl.sweep) begin
			if (32'(sw_i_q) < 32'(req_q.buffer_count)) begin
				link_mem[mem_addr(sw_set_q, sw_i_q)] <=
					(32'(sw_i_q) + 1 < 32'(req_q.buffer_count)) ? sw_i_q + BW'(1) : BW'(BUFS);
			end
		end else if (ctl.exec && lk_we) begin
			link_mem[lk_wa] <= lk_wd;
		end
		rd_link_q <= link_mem[lk_ra];
	end

	// Result register: load on execute, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.exec) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			out_q.status        <= st;
			out_q.result_cab    <= 2'(rcab);
			out_q.result_buffer <= 4'(rbuf);
		end
	end

	assign rsp_valid      = out_valid_q;
	assign rsp_word       = out_q;
	assign sts.out_busy   = out_valid_q;
	assign sts.create_go  = do_create;
	assign sts.sweep_last = (sw_i_q == BW'(BUFS - 1));

endmodule

FILE: hw/rtl/cyclic_async_buffer_manager_top.sv
// Buffer index manager for CABS cyclic asynchronous buffer sets of up to BUFS
// buffers each. One command word in gives one result word out. After the
// accepting edge the word passes a read step, which reads the use-count and
// link memories, and then an execute step, which loads the result register.
// The execute step waits while an earlier result is still held, so a waiting
// result does not block acceptance. A word is taken whenever the controller
// is idle, so no new word is taken before the last one has executed; a
// successful create then sweeps the set's rows of both memories, one buffer
// per cycle, before the next word is taken.
module cyclic_async_buffer_manager_top #(
	parameter int CABS = 4,
	parameter int BUFS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  cabm_pkg::cabm_req_t cmd_word,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output cabm_pkg::cabm_rsp_t rsp_word
);
	import cabm_pkg::*;

	cabm_ctl_t ctl;
	cabm_sts_t sts;

	cabm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	cabm_dp #(
		.CABS (CABS),
		.BUFS (BUFS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.cmd_word  (cmd_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word)
	);

`ifndef SYNTHESIS
	a_exec_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec |-> !rsp_valid)
		else $error("execute while a result is pending");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> cmd_stall)
		else $error("second word accepted during execution");
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(ctl.exec))
		else $error("result raised without execute");
	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.exec && ctl.sweep) && !(ctl.load && (ctl.exec || ctl.sweep)))
		else $error("controller commands overlap");
`endif

endmodule
